@@ rtl/lsc_pkg.sv @@
// lsc_pkg: shared types, constants and the cordic arctangent table
// for the lidar scan curvature block; no dependencies
package lsc_pkg;

    localparam int HALF_WIN_DEF    = 5;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int CORDIC_STEPS    = 16;
    localparam int XY_W            = 17;
    localparam int CURV_W          = 42;
    localparam int IDX_W           = 12;

    localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX   = 2'd1;
    localparam logic [1:0] REG_ANGLE_START = 2'd2;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd3;

    localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;

    // work item from the front end to the back end
    typedef struct packed {
        logic [15:0] range_mm;
        logic [15:0] angle;
        logic        ok;
        logic        emit_ok;
        logic [15:0] center_idx;
    } t_job;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd0:  v = 32'd536870912;
            4'd1:  v = 32'd316933406;
            4'd2:  v = 32'd167458907;
            4'd3:  v = 32'd85004756;
            4'd4:  v = 32'd42667331;
            4'd5:  v = 32'd21354465;
            4'd6:  v = 32'd10679838;
            4'd7:  v = 32'd5340245;
            4'd8:  v = 32'd2670163;
            4'd9:  v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            4'd15: v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/lsc_front.sv @@
// lsc_front: takes range samples, checks range, tracks sample index and angle
// depends on lsc_pkg
module lsc_front #(
    parameter int HALF_WIN    = lsc_pkg::HALF_WIN_DEF,
    parameter int MAX_SAMPLES = lsc_pkg::MAX_SAMPLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [15:0]      i_range_mm,
    input  logic             i_not_finite,
    input  logic             i_scan_start,
    input  logic [15:0]      i_range_min,
    input  logic [15:0]      i_range_max,
    input  logic [15:0]      i_angle_start,
    input  logic [15:0]      i_angle_step,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output lsc_pkg::t_job    o_job
);
    import lsc_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int WIN_LEN = 2 * HALF_WIN + 1;

    logic [CNT_W-1:0]   r_count;
    logic [15:0]        r_angle;
    logic [WIN_LEN-1:0] r_valid;
    logic [CNT_W-1:0]   idx;
    logic [15:0]        ang;
    logic [WIN_LEN-1:0] vbits;
    logic [WIN_LEN-1:0] n_valid;
    logic               ok;
    logic               fire;

    assign o_ready = i_job_ready;
    assign fire    = i_valid && i_job_ready;

    always_comb begin
        idx   = i_scan_start ? '0 : r_count;
        ang   = i_scan_start ? i_angle_start : r_angle;
        vbits = i_scan_start ? '0 : r_valid;
        ok    = !i_not_finite && i_range_mm >= i_range_min && i_range_mm <= i_range_max;
        n_valid = {ok, vbits[WIN_LEN-1:1]};
    end

    assign o_job_valid       = fire && (idx < CNT_W'(MAX_SAMPLES));
    assign o_job.range_mm    = i_range_mm;
    assign o_job.angle       = ang;
    assign o_job.ok          = ok;
    assign o_job.emit_ok     = (idx >= CNT_W'(2 * HALF_WIN)) && (&n_valid);
    assign o_job.center_idx  = 16'(idx - CNT_W'(HALF_WIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_angle <= '0;
            r_valid <= '0;
        end else if (fire) begin
            if (idx < CNT_W'(MAX_SAMPLES)) begin
                r_count <= idx + 1'b1;
                r_angle <= ang + i_angle_step;
                r_valid <= n_valid;
            end else begin
                r_count <= idx;
                r_angle <= ang;
                r_valid <= vbits;
            end
        end
    end

endmodule

@@ rtl/lsc_queue.sv @@
// lsc_queue: two-entry job queue between front and back end
// depends on lsc_pkg
module lsc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lsc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output lsc_pkg::t_job o_job
);
    import lsc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/lsc_back.sv @@
// lsc_back: cordic, millimetre scaling, window shift and curvature
// depends on lsc_pkg
module lsc_back #(
    parameter int HALF_WIN = lsc_pkg::HALF_WIN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    output logic                      o_job_ready,
    input  lsc_pkg::t_job             i_job,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [lsc_pkg::IDX_W-1:0] o_center_index,
    output logic signed [16:0]        o_center_x_mm,
    output logic signed [16:0]        o_center_y_mm,
    output logic [lsc_pkg::CURV_W-1:0] o_curvature
);
    import lsc_pkg::*;

    localparam int WIN_LEN = 2 * HALF_WIN + 1;
    localparam int SUM_W   = XY_W + 6;
    localparam int SQ_W    = 2 * SUM_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ROT  = 7'b0000010,
        ST_MULX = 7'b0000100,
        ST_MULY = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_SQ   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic                    r_flip;
    logic signed [34:0]      r_cx;
    logic signed [34:0]      r_cy;
    logic signed [34:0]      r_cz;
    logic [3:0]              r_it;
    logic signed [XY_W-1:0]  r_wx [WIN_LEN];
    logic signed [XY_W-1:0]  r_wy [WIN_LEN];
    logic signed [SUM_W-1:0] r_sumx;
    logic signed [SUM_W-1:0] r_sumy;
    logic signed [XY_W-1:0]  r_px;
    logic signed [SUM_W-1:0] r_dx;
    logic signed [SUM_W-1:0] r_dy;
    logic [SUM_W-1:0]        r_ay;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_oval;
    logic [IDX_W-1:0]        r_oidx;
    logic signed [XY_W-1:0]  r_ox;
    logic signed [XY_W-1:0]  r_oy;
    logic [CURV_W-1:0]       r_ocurv;

    logic [15:0]             a_flip;
    logic                    flip;
    logic signed [34:0]      xs;
    logic signed [34:0]      ys;
    logic signed [34:0]      sel;
    logic signed [52:0]      prod;
    logic signed [52:0]      q;
    logic signed [XY_W-1:0]  sat;
    logic signed [XY_W-1:0]  py;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SQ_W-1:0]  dxsq;
    logic [SQ_W-1:0]         aysq;
    logic [SQ_W:0]           csum;

    assign o_job_ready    = r_state == ST_IDLE;
    assign o_valid        = r_oval;
    assign o_center_index = r_oidx;
    assign o_center_x_mm  = r_ox;
    assign o_center_y_mm  = r_oy;
    assign o_curvature    = r_ocurv;

    always_comb begin
        flip   = i_job.angle[15] ^ i_job.angle[14];
        a_flip = flip ? (i_job.angle ^ 16'h8000) : i_job.angle;
        xs     = r_cx >>> r_it;
        ys     = r_cy >>> r_it;
        sel    = (r_state == ST_MULX) ? r_cx : r_cy;
        if (r_flip) sel = -sel;
        prod   = $signed({37'd0, r_job.range_mm}) * 53'(sel) + 53'sd536870912;
        q      = prod >>> 30;
        if (q < -53'sd65536) sat = -17'sd65536;
        else if (q > 53'sd65535) sat = 17'sd65535;
        else sat = q[XY_W-1:0];
        py = r_job.ok ? sat : '0;
        // running window sums: neighbour sum minus ten centres is sum minus eleven centres
        sx = r_sumx - SUM_W'(WIN_LEN) * SUM_W'(r_wx[HALF_WIN]);
        sy = r_sumy - SUM_W'(WIN_LEN) * SUM_W'(r_wy[HALF_WIN]);
        dxsq = r_dx * r_dx;
        aysq = r_ay * r_ay;
        csum = {1'b0, r_sq} + {1'b0, aysq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
            r_sumx  <= '0;
            r_sumy  <= '0;
            for (int i = 0; i < WIN_LEN; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else begin
            if (r_state == ST_OUT && (!r_oval || i_ready)) r_oval <= 1'b1;
            else if (r_oval && i_ready) r_oval <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job  <= i_job;
                        r_flip <= flip;
                        r_cx   <= CORDIC_GAIN;
                        r_cy   <= '0;
                        r_cz   <= 35'($signed(a_flip)) <<< 16;
                        r_it   <= '0;
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (!r_cz[34]) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - 35'(atan_turn(r_it));
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + 35'(atan_turn(r_it));
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 4'(CORDIC_STEPS - 1)) r_state <= ST_MULX;
                end
                ST_MULX: begin
                    r_px    <= py;
                    r_state <= ST_MULY;
                end
                ST_MULY: begin
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        r_wx[i] <= r_wx[i+1];
                        r_wy[i] <= r_wy[i+1];
                    end
                    r_wx[WIN_LEN-1] <= r_px;
                    r_wy[WIN_LEN-1] <= py;
                    r_sumx <= r_sumx - SUM_W'(r_wx[0]) + SUM_W'(r_px);
                    r_sumy <= r_sumy - SUM_W'(r_wy[0]) + SUM_W'(py);
                    r_state <= r_job.emit_ok ? ST_SUM : ST_IDLE;
                end
                ST_SUM: begin
                    r_dx <= sx;
                    r_dy <= sy;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_ay <= r_dy[SUM_W-1] ? SUM_W'(-r_dy) : SUM_W'(r_dy);
                    r_sq <= dxsq;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_oval || i_ready) begin
                        r_oidx  <= r_job.center_idx[IDX_W-1:0];
                        r_ox    <= r_wx[HALF_WIN];
                        r_oy    <= r_wy[HALF_WIN];
                        r_ocurv <= (csum[SQ_W:CURV_W] != '0) ? '1 : csum[CURV_W-1:0];
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/lidar_scan_curvature.sv @@
// lidar_scan_curvature: top level of the scan point curvature block
// depends on lsc_pkg, lsc_front, lsc_queue, lsc_back
//
// samples enter on the s_axis channel: range, no-return flag, scan start flag
// results leave on m_axis: centre index, centre x and y in mm, curvature
// the user must write registers on cfg channel (index, data) only while idle; unchecked
// the front end checks the range and tracks index, angle and window validity
// in the cycle of acceptance, then hands the item to a two-entry queue
// the back end runs a 16-step cordic, range scaling in ST_MULX and ST_MULY, a window
// shift in ST_MULY, then curvature math and output in ST_SUM, ST_SQ and ST_OUT, which
// are skipped when no result is made; it takes a new item only back in ST_IDLE
// reset clears counters, window validity and the registers to defaults
// a stalled receiver holds the result register; the queue keeps taking items
// until full, then s_axis_tready drops
module lidar_scan_curvature #(
    parameter int HALF_WIN    = lsc_pkg::HALF_WIN_DEF,
    parameter int MAX_SAMPLES = lsc_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // range_mm
    input  logic [1:0]  s_axis_tuser,  // not_finite, scan_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // center_index, center_x_mm, center_y_mm, curvature
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lsc_pkg::*;

    logic [15:0] r_range_min;
    logic [15:0] r_range_max;
    logic [15:0] r_angle_start;
    logic [15:0] r_angle_step;
    logic        f_valid;
    logic        q_ready;
    t_job        f_job;
    logic        q_valid;
    logic        b_ready;
    t_job        q_job;
    logic [IDX_W-1:0]  o_idx;
    logic signed [16:0] o_x;
    logic signed [16:0] o_y;
    logic [CURV_W-1:0] o_curv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= 16'd150;
            r_range_max   <= 16'd25000;
            r_angle_start <= 16'd0;
            r_angle_step  <= 16'd41;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RANGE_MIN:   r_range_min   <= i_cfg_data;
                REG_RANGE_MAX:   r_range_max   <= i_cfg_data;
                REG_ANGLE_START: r_angle_start <= i_cfg_data;
                REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsc_front #(.HALF_WIN(HALF_WIN), .MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_range_mm(s_axis_tdata), .i_not_finite(s_axis_tuser[0]),
        .i_scan_start(s_axis_tuser[1]),
        .i_range_min(r_range_min), .i_range_max(r_range_max),
        .i_angle_start(r_angle_start), .i_angle_step(r_angle_step),
        .o_job_valid(f_valid), .i_job_ready(q_ready), .o_job(f_job)
    );

    lsc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(q_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(b_ready), .o_job(q_job)
    );

    lsc_back #(.HALF_WIN(HALF_WIN)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .o_job_ready(b_ready), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_center_index(o_idx), .o_center_x_mm(o_x), .o_center_y_mm(o_y),
        .o_curvature(o_curv)
    );

    assign m_axis_tdata = {o_curv, o_y, o_x, o_idx};

    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("cfg not ready");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_q_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == q_ready)
        else $error("input ready mismatch");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for lidar_scan_curvature with its own cordic and window model
// depends on lsc_pkg and the rtl of lidar_scan_curvature; directed rows, then randomized scans
module testbench;
    import lsc_pkg::*;

    localparam int HALF    = 5;
    localparam int WLEN    = 2 * HALF + 1;
    localparam int NSAMP   = 4096;
    localparam int LIMIT   = 3000;
    localparam int SETTLE  = 120;
    localparam longint XY_LO = -65536;
    localparam longint XY_HI = 65535;
    localparam longint CURV_SAT = 64'h3FF_FFFF_FFFF;

    typedef struct packed {
        logic [41:0] curv;
        logic [16:0] y;
        logic [16:0] x;
        logic [11:0] idx;
    } point_t;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        nf;
        logic        ss;
        logic        none;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    lidar_scan_curvature i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    const longint atan_tab [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    // model state
    logic [15:0] m_min, m_max, m_start, m_step, m_angle;
    longint      win_x [WLEN];
    longint      win_y [WLEN];
    bit          win_v [WLEN];
    int          m_count;

    point_t      expected_points [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_points = 0;
    int          n_cfg = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;
    int          quiet = 0;

    function automatic void cordic_sin_cos(input logic [15:0] ang, output longint c,
                                           output longint s);
        longint x, y, z, xs, ys;
        logic [15:0] a, q;
        bit flip;
        a = ang;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        q = a + 16'h4000;
        if (q >= 16'h8000) begin
            flip = 1'b1;
            a = a ^ 16'h8000;
        end
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint to_mm(input logic [15:0] r, input longint v);
        longint q;
        q = (longint'(r) * v + (longint'(1) <<< 29)) >>> 30;
        if (q < XY_LO) q = XY_LO;
        if (q > XY_HI) q = XY_HI;
        return q;
    endfunction

    function automatic void model_reset();
        m_min = 16'd150; m_max = 16'd25000; m_start = 16'd0; m_step = 16'd41;
        for (int i = 0; i < WLEN; i++) begin
            win_x[i] = 0; win_y[i] = 0; win_v[i] = 1'b0;
        end
        m_count = 0;
        m_angle = 16'd0;
    endfunction

    // returns the number of points predicted for this item
    function automatic int predict_point(input logic [15:0] r, input bit nf, input bit ss);
        longint px, py, dx, dy, c, s, ux, uy, cv;
        logic [15:0] ang;
        int idx;
        bit ok, all;
        point_t p;
        px = 0; py = 0; dx = 0; dy = 0; all = 1'b1;
        if (ss) begin
            for (int i = 0; i < WLEN; i++) win_v[i] = 1'b0;
            m_count = 0;
            m_angle = m_start;
        end
        idx = m_count;
        if (idx >= NSAMP) return 0;
        ang = m_angle;
        m_count = idx + 1;
        m_angle = m_angle + m_step;
        ok = !nf && r >= m_min && r <= m_max;
        if (ok) begin
            cordic_sin_cos(ang, c, s);
            px = to_mm(r, c);
            py = to_mm(r, s);
        end
        for (int i = 0; i < WLEN - 1; i++) begin
            win_x[i] = win_x[i+1]; win_y[i] = win_y[i+1]; win_v[i] = win_v[i+1];
        end
        win_x[WLEN-1] = px; win_y[WLEN-1] = py; win_v[WLEN-1] = ok;
        if (idx < 2 * HALF) return 0;
        for (int i = 0; i < WLEN; i++) if (!win_v[i]) all = 1'b0;
        if (!all) return 0;
        for (int i = 0; i < WLEN; i++) begin
            if (i != HALF) begin
                dx += win_x[i] - win_x[HALF];
                dy += win_y[i] - win_y[HALF];
            end
        end
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        cv = ux * ux + uy * uy;
        if (cv > CURV_SAT) cv = CURV_SAT;
        p.idx = 12'(idx - HALF);
        p.x = 17'(win_x[HALF]);
        p.y = 17'(win_y[HALF]);
        p.curv = 42'(cv);
        expected_points.insert(expected_points.size(), p);
        return 1;
    endfunction

    task automatic send_sample(input logic [15:0] r, input bit nf, input bit ss,
                               output int made);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r;
        s_axis_tuser <= {ss, nf};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        made = predict_point(r, nf, ss);
        n_items++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] mn, input logic [15:0] mx,
                              input logic [15:0] st, input logic [15:0] sp);
        logic [15:0] vals [4];
        vals = '{mn, mx, st, sp};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
            case (2'(i))
                REG_RANGE_MIN:   m_min = vals[i];
                REG_RANGE_MAX:   m_max = vals[i];
                REG_ANGLE_START: m_start = vals[i];
                REG_ANGLE_STEP:  m_step = vals[i];
                default: ;
            endcase
            n_cfg++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_range();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return 16'($urandom());
        if (k == 1) return m_min;
        if (k == 2) return m_max;
        if (m_min <= m_max) return 16'($urandom_range(m_min, m_max));
        return 16'($urandom());
    endfunction

    // receiver side
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end
            w = rx_idle ? $urandom_range(0, 17) : 0;
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready) && !hold_req);
        end
    end

    always @(posedge i_clk) begin
        point_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_points.size() == 0) begin
                $display("%0t unexpected point: actual %h", $time, got);
                errors++;
            end else begin
                want = expected_points.pop_front();
                n_points++;
                if (got.idx !== want.idx) begin
                    $display("%0t center_index: expected %0d actual %0d", $time,
                             want.idx, got.idx);
                    errors++;
                end
                if (got.x !== want.x) begin
                    $display("%0t center_x_mm: expected %0d actual %0d", $time,
                             $signed(want.x), $signed(got.x));
                    errors++;
                end
                if (got.y !== want.y) begin
                    $display("%0t center_y_mm: expected %0d actual %0d", $time,
                             $signed(want.y), $signed(got.y));
                    errors++;
                end
                if (got.curv !== want.curv) begin
                    $display("%0t curvature: expected %0d actual %0d", $time,
                             want.curv, got.curv);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    dir_row_t dir_tab [0:20] = '{
        // before any scan start
        '{16'd1000, 1'b0, 1'b0, 1'b1}, '{16'd1000, 1'b0, 1'b0, 1'b1},
        '{16'd1000, 1'b0, 1'b0, 1'b1},
        // scan start, then a clean run
        '{16'd1000, 1'b0, 1'b1, 1'b1}, '{16'd1040, 1'b0, 1'b0, 1'b1},
        '{16'd1080, 1'b0, 1'b0, 1'b1}, '{16'd1120, 1'b0, 1'b0, 1'b1},
        '{16'd1160, 1'b0, 1'b0, 1'b1}, '{16'd1200, 1'b0, 1'b0, 1'b1},
        '{16'd1240, 1'b0, 1'b0, 1'b1}, '{16'd1280, 1'b0, 1'b0, 1'b1},
        '{16'd1320, 1'b0, 1'b0, 1'b1}, '{16'd1360, 1'b0, 1'b0, 1'b1},
        '{16'd5000, 1'b0, 1'b0, 1'b0}, '{16'd150,  1'b0, 1'b0, 1'b0},
        '{16'd25000, 1'b0, 1'b0, 1'b0},
        // invalid samples
        '{16'd1000, 1'b1, 1'b0, 1'b1}, '{16'd0,    1'b0, 1'b0, 1'b1},
        '{16'd149,  1'b0, 1'b0, 1'b1}, '{16'd25001, 1'b0, 1'b0, 1'b1},
        '{16'd65535, 1'b0, 1'b0, 1'b1}
    };

    initial begin
        int made;
        logic [15:0] mn, mx;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_sample(dir_tab[i].range_mm, dir_tab[i].nf, dir_tab[i].ss, made);
            if (dir_tab[i].none && made != 0) begin
                $display("%0t directed row %0d: expected no point, model gave %0d",
                         $time, i, made);
                errors++;
            end
        end
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_regs(16'd0, 16'hFFFF, 16'd0, 16'd0);
                1: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_regs(16'd30000, 16'd100, 16'h4000, 16'd77);
                3: write_regs(16'd0, 16'hFFFF, 16'hC000, 16'h8000);
                default: begin
                    mn = 16'($urandom_range(0, 2000));
                    mx = 16'($urandom_range(20000, 65535));
                    write_regs(mn, mx, 16'($urandom()), 16'($urandom()));
                end
            endcase
            if (ph == 5) hold_req = 1'b1;
            tx_idle = (ph != 6);
            rx_idle = (ph != 6);
            // new angle_start only counts from the next scan start
            for (int k = 0; k < 45; k++)
                send_sample(pick_range(), $urandom_range(0, 23) == 0,
                            (k == 20) || ($urandom_range(0, 59) == 0), made);
            wait_idle();
        end

        // a fresh scan with dense valid samples
        write_regs(16'd0, 16'hFFFF, 16'h2000, 16'd16);
        for (int k = 0; k < 30; k++)
            send_sample(pick_range(), 1'b0, k == 0, made);
        wait_idle();

        $display("run covered %0d samples, %0d points checked, %0d register writes",
                 n_items, n_points, n_cfg);
        $display("phases: range extremes, empty range window, back-to-back, long output stall");
        if (errors == 0 && expected_points.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
